// ===== src/hba_pkg.sv =====
package hba_pkg;

    localparam int POS_W = 10;
    localparam int CNT_W = 11;
    localparam int OP_W = 3;

    // Summary bits examined per scan cycle.
    localparam int SUM_CHUNK_BITS = 32;

    // Shift used for the reciprocal multiplies that split an index into word and bit.
    localparam int RECIP_SHIFT = 20;

    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK  = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND  = 3'd4;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [POS_W-1:0] position;
        logic             fill_free;
    } req_item_t;

    typedef struct packed {
        logic [POS_W-1:0] result_index;
        logic             status;
    } rsp_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PREP,
        ST_SETUP,
        ST_SCAN,
        ST_READ,
        ST_CHECK,
        ST_WRITE,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load_in;
        logic init_start;
        logic init_step;
        logic prep;
        logic setup;
        logic from_zero;
        logic scan;
        logic read;
        logic wbit_from_start;
        logic check;
        logic write;
        logic write_free;
        logic load_out;
        logic out_found;
        logic out_fail;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_range;
        logic scan_hit;
        logic scan_end;
        logic check_hit;
        logic init_last;
        logic out_busy;
    } dp_stat_t;

endpackage

// ===== src/hba_ctrl.sv =====
module hba_ctrl
    import hba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [OP_W-1:0]     req_opcode,
    input  dp_stat_t            stat,
    output ctrl_cmd_t           cmd
);

    state_t            state_reg;
    state_t            state_next;
    logic [OP_W-1:0]   op_reg;
    logic [OP_W-1:0]   op_next;
    logic              fail_reg;
    logic              fail_next;
    logic              found_reg;
    logic              found_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_INIT;
            fail_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            fail_reg  <= fail_next;
            found_reg <= found_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        fail_next  = fail_reg;
        found_next = found_reg;
        cmd        = '0;
        req_stall  = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    op_next     = req_opcode;
                    fail_next   = 1'b0;
                    found_next  = 1'b0;
                    if (req_opcode == OP_INIT)
                    begin
                        cmd.init_start = 1'b1;
                        state_next     = ST_INIT;
                    end
                    else if (req_opcode == OP_ALLOC || req_opcode == OP_FREE ||
                             req_opcode == OP_MARK || req_opcode == OP_FIND)
                    begin
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        fail_next  = 1'b1;
                        state_next = ST_FIN;
                    end
                end
            end

            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (stat.init_last)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_SETUP;
            end

            ST_SETUP:
            begin
                cmd.setup     = 1'b1;
                cmd.from_zero = (op_reg == OP_ALLOC);
                if (op_reg == OP_ALLOC)
                begin
                    state_next = ST_SCAN;
                end
                else if (!stat.in_range)
                begin
                    fail_next  = 1'b1;
                    state_next = ST_FIN;
                end
                else if (op_reg == OP_FIND)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end

            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_hit)
                begin
                    state_next = ST_READ;
                end
                else if (stat.scan_end)
                begin
                    fail_next  = 1'b1;
                    state_next = ST_FIN;
                end
            end

            ST_READ:
            begin
                cmd.read = 1'b1;
                if (op_reg == OP_FREE || op_reg == OP_MARK)
                begin
                    cmd.wbit_from_start = 1'b1;
                    state_next          = ST_WRITE;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.check_hit)
                begin
                    found_next = 1'b1;
                    state_next = (op_reg == OP_ALLOC) ? ST_WRITE : ST_FIN;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_WRITE:
            begin
                cmd.write      = 1'b1;
                cmd.write_free = (op_reg == OP_FREE);
                state_next     = ST_FIN;
            end

            ST_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.out_found = found_reg;
                    cmd.out_fail  = fail_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A search-only request must never reach the leaf write.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |-> op_reg != OP_FIND)
        else $error("leaf write issued for a find request");

    // A reported hit and a reported failure never come together.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(cmd.out_found && cmd.out_fail))
        else $error("result marked both found and failed");

endmodule

// ===== src/hba_datapath.sv =====
module hba_datapath
    import hba_pkg::*;
#(
    parameter int MAX_OBJECTS = 1024,
    parameter int WORD_BITS   = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  req_item_t         req_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_item_t         rsp_item,
    input  ctrl_cmd_t         cmd,
    output dp_stat_t          stat
);

    localparam int LEAF_COUNT = (MAX_OBJECTS + WORD_BITS - 1) / WORD_BITS;
    localparam int LI         = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;
    localparam int LWW        = $clog2(LEAF_COUNT + 1);
    localparam int NCHUNK     = (LEAF_COUNT + SUM_CHUNK_BITS - 1) / SUM_CHUNK_BITS;
    localparam int SUM_W      = NCHUNK * SUM_CHUNK_BITS;
    localparam int CBW        = LWW + $clog2(SUM_CHUNK_BITS) + 1;
    localparam int CHW        = $clog2(SUM_CHUNK_BITS);
    localparam int WBW        = $clog2(WORD_BITS);
    localparam int BASE_W     = CNT_W + 1;
    localparam int RECIP      = ((2 ** RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RW         = $clog2(RECIP + 1);
    localparam int PW         = CNT_W + RW;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_OBJECTS);

    logic [CNT_W-1:0]     count_reg;
    logic [SUM_W-1:0]     summary_reg;
    logic [SUM_W-1:0]     summary_next;
    logic [WORD_BITS-1:0] leaf_mem [LEAF_COUNT];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_zero_reg;

    logic [POS_W-1:0]     pos_reg;
    logic                 fill_reg;
    logic [POS_W-1:0]     q_reg;
    logic [LWW-1:0]       limw_reg;
    logic [LWW-1:0]       start_word_reg;
    logic [WBW-1:0]       start_bit_reg;
    logic [LWW-1:0]       cur_reg;
    logic [LWW-1:0]       cur_next;
    logic [BASE_W-1:0]    base_reg;
    logic [WBW-1:0]       wbit_reg;
    logic [POS_W-1:0]     found_reg;
    logic                 rsp_valid_reg;
    rsp_item_t            rsp_item_reg;

    logic [CNT_W-1:0]     limit;
    logic [PW-1:0]        q_prod;
    logic [PW-1:0]        limw_prod;
    logic [POS_W-1:0]     qwb_prod;
    logic [LI-1:0]        cur_idx;

    logic [CBW-1:0]       cur_ext;
    logic [CBW-1:0]       limw_ext;
    logic [CBW-1:0]       chunk_base;
    logic [CBW-1:0]       chunk_next;
    logic [SUM_CHUNK_BITS-1:0] chunk_bits;
    logic [SUM_CHUNK_BITS-1:0] scan_mask;
    logic [CHW-1:0]       scan_off;
    logic [CBW-1:0]       hit_word;

    logic [WORD_BITS-1:0] lim_mask;
    logic [WORD_BITS-1:0] leaf_word;
    logic [WORD_BITS-1:0] check_mask;
    logic [WBW-1:0]       check_off;
    logic [POS_W-1:0]     found_idx;
    logic [WORD_BITS-1:0] wr_word;
    logic                 mem_we;

    assign cfg_ready = 1'b1;
    assign limit     = (count_reg > MAX_CNT) ? MAX_CNT : count_reg;
    assign cur_idx   = cur_reg[LI-1:0];

    // Word and bit of an index through a reciprocal multiply; exact for 11-bit operands.
    assign q_prod    = PW'(pos_reg) * PW'(RECIP);
    assign limw_prod = PW'(limit + CNT_W'(WORD_BITS - 1)) * PW'(RECIP);
    assign qwb_prod  = POS_W'(q_reg * POS_W'(WORD_BITS));

    // Summary scan: one chunk of summary bits per cycle, from the current word up.
    assign cur_ext    = CBW'(cur_reg);
    assign limw_ext   = CBW'(limw_reg);
    assign chunk_base = cur_ext & ~CBW'(SUM_CHUNK_BITS - 1);
    assign chunk_next = chunk_base + CBW'(SUM_CHUNK_BITS);
    assign chunk_bits = SUM_CHUNK_BITS'(summary_reg >> chunk_base);

    always_comb
    begin
        scan_off = '0;
        for (int i = 0; i < SUM_CHUNK_BITS; i++)
        begin
            scan_mask[i] = chunk_bits[i] && (chunk_base + CBW'(i) >= cur_ext) &&
                           (chunk_base + CBW'(i) < limw_ext);
        end
        for (int i = SUM_CHUNK_BITS - 1; i >= 0; i--)
        begin
            if (scan_mask[i])
            begin
                scan_off = CHW'(i);
            end
        end
    end

    assign hit_word = chunk_base + CBW'(scan_off);

    // Leaf word check: bits below the count, and at or after the start bit in the start word.
    assign leaf_word = rd_zero_reg ? '0 : rd_data_reg;

    always_comb
    begin
        check_off = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            lim_mask[i]   = (base_reg + BASE_W'(i)) < BASE_W'(limit);
            check_mask[i] = leaf_word[i] && lim_mask[i] &&
                            ((cur_reg != start_word_reg) || (WBW'(i) >= start_bit_reg));
        end
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (check_mask[i])
            begin
                check_off = WBW'(i);
            end
        end
    end

    assign found_idx = POS_W'(base_reg + BASE_W'(check_off));

    always_comb
    begin
        wr_word = leaf_word;
        if (cmd.init_step)
        begin
            wr_word = lim_mask & {WORD_BITS{fill_reg}};
        end
        else
        begin
            wr_word[wbit_reg] = cmd.write_free;
        end
    end

    assign mem_we = cmd.init_step || cmd.write;

    always_comb
    begin
        summary_next = summary_reg;
        if (mem_we)
        begin
            summary_next[cur_idx] = |wr_word;
        end
    end

    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.init_start)
        begin
            cur_next = '0;
        end
        else if (cmd.init_step)
        begin
            cur_next = cur_reg + LWW'(1);
        end
        else if (cmd.setup)
        begin
            cur_next = cmd.from_zero ? '0 : LWW'(q_reg);
        end
        else if (cmd.scan)
        begin
            cur_next = (|scan_mask) ? LWW'(hit_word) : LWW'(chunk_next);
        end
        else if (cmd.check && !(|check_mask))
        begin
            cur_next = cur_reg + LWW'(1);
        end
    end

    assign stat.in_range  = {1'b0, pos_reg} < limit;
    assign stat.scan_hit  = |scan_mask;
    assign stat.scan_end  = !(|scan_mask) && (chunk_next >= limw_ext);
    assign stat.check_hit = |check_mask;
    assign stat.init_last = (cur_reg == LWW'(LEAF_COUNT - 1));
    assign stat.out_busy  = rsp_valid_reg && rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_RESET;
            summary_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            summary_reg <= summary_next;
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            pos_reg  <= req_item.position;
            fill_reg <= req_item.fill_free;
        end
        if (cmd.prep)
        begin
            q_reg    <= POS_W'(q_prod >> RECIP_SHIFT);
            limw_reg <= LWW'(limw_prod >> RECIP_SHIFT);
        end
        if (cmd.setup)
        begin
            start_word_reg <= cmd.from_zero ? '0 : LWW'(q_reg);
            start_bit_reg  <= cmd.from_zero ? '0 : WBW'(pos_reg - qwb_prod);
        end
        cur_reg <= cur_next;
        if (cmd.init_start)
        begin
            base_reg <= '0;
        end
        else if (cmd.init_step)
        begin
            base_reg <= base_reg + BASE_W'(WORD_BITS);
        end
        else if (cmd.read)
        begin
            base_reg <= BASE_W'(cur_reg * BASE_W'(WORD_BITS));
        end
        if (cmd.wbit_from_start)
        begin
            wbit_reg <= start_bit_reg;
        end
        else if (cmd.check)
        begin
            wbit_reg <= check_off;
        end
        if (cmd.check)
        begin
            found_reg <= found_idx;
        end
        if (cmd.load_out)
        begin
            rsp_item_reg.result_index <= cmd.out_found ? found_reg : pos_reg;
            rsp_item_reg.status       <= cmd.out_fail ? STATUS_FAIL : STATUS_OK;
        end
    end

    // Leaf memory: one port, read data registered. A word whose summary bit is clear
    // reads as all busy, so words never written since reset need no clearing pass.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            leaf_mem[cur_idx] <= wr_word;
        end
        if (cmd.read)
        begin
            rd_data_reg <= leaf_mem[cur_idx];
            rd_zero_reg <= !summary_reg[cur_idx];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // The summary bit of a written word tracks whether the word holds any free object.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> summary_reg[$past(cur_idx)] == $past(|wr_word))
        else $error("summary bit out of step with leaf word");

    // A result only appears after the controller loads one.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.load_out))
        else $error("result valid without a load");

    // A found object always lies below the count in effect.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.check && (|check_mask)) |-> ({1'b0, found_idx} < limit))
        else $error("found object beyond the count");

endmodule

// ===== src/hierarchical_bitmap_allocator.sv =====
// Two-level free map allocator: a leaf memory with one bit per object (set means free)
// and a summary register with one bit per leaf word that holds a free object. One request
// is in work at a time; a finished item waits in the output register while the next
// request is taken. Init writes one leaf word per cycle; free and mark busy go through
// the prep, setup, read and write states; find goes through prep, setup, scan, read and
// check, and allocate adds a write after the check. The summary scan covers a block of
// 32 leaf words at a time, and a leaf word that holds free objects only below the start
// position or at or above the count adds a scan, a read and a check. The request time
// is set by the single-port leaf memory read-modify-write and the 32-bit-per-cycle
// summary scan. Configuration writes are always accepted.
module hierarchical_bitmap_allocator
    import hba_pkg::*;
#(
    parameter int MAX_OBJECTS = 1024,
    parameter int WORD_BITS   = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_item_t        req_item,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_item_t        rsp_item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    hba_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_opcode (req_item.opcode),
        .stat       (stat),
        .cmd        (cmd)
    );

    hba_datapath #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .WORD_BITS   (WORD_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== dv/tb_hierarchical_bitmap_allocator.sv =====
`timescale 1ns / 1ps

module tb_hierarchical_bitmap_allocator;
    import hba_pkg::*;

    localparam int OBJ_TOTAL = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEMS_PER_PHASE = 184;
    localparam int PHASES = 9;
    localparam int HOLD_CYCLES = 400;

    // Tracks the free map and the count, and holds the results still owed by the block.
    class free_map_checker;
        bit [OBJ_TOTAL-1:0] free_map;
        logic [CNT_W-1:0] object_count;
        rsp_item_t owed_results[$];
        int errors;
        int checked;
        int op_seen[8];
        int grants;

        function new();
            free_map = '0;
            object_count = COUNT_RESET;
            errors = 0;
            checked = 0;
            grants = 0;
            foreach (op_seen[i])
                op_seen[i] = 0;
        endfunction

        function int unsigned count_limit();
            return (object_count > OBJ_TOTAL) ? OBJ_TOTAL : object_count;
        endfunction

        // Lowest free object at or after start and below the count in effect.
        function bit lowest_free(int unsigned start, output int unsigned hit);
            int unsigned lim;
            lim = count_limit();
            hit = 0;
            for (int unsigned i = start; i < lim; i++)
            begin
                if (free_map[i])
                begin
                    hit = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function rsp_item_t apply_request(req_item_t r);
            rsp_item_t o;
            int unsigned lim;
            int unsigned hit;
            lim = count_limit();
            o.result_index = r.position;
            o.status = STATUS_FAIL;
            case (r.opcode)
                OP_INIT:
                begin
                    for (int i = 0; i < OBJ_TOTAL; i++)
                        free_map[i] = r.fill_free && (i < lim);
                    o.status = STATUS_OK;
                end
                OP_ALLOC:
                begin
                    if (lowest_free(0, hit))
                    begin
                        free_map[hit] = 1'b0;
                        o.result_index = POS_W'(hit);
                        o.status = STATUS_OK;
                        grants++;
                    end
                end
                OP_FREE, OP_MARK:
                begin
                    if (r.position < lim)
                    begin
                        free_map[r.position] = (r.opcode == OP_FREE);
                        o.status = STATUS_OK;
                    end
                end
                OP_FIND:
                begin
                    if (lowest_free(r.position, hit))
                    begin
                        o.result_index = POS_W'(hit);
                        o.status = STATUS_OK;
                    end
                end
                default: ;
            endcase
            return o;
        endfunction

        function void note_request(req_item_t r);
            op_seen[r.opcode]++;
            owed_results.push_back(apply_request(r));
        endfunction

        function void report(string msg);
            errors++;
            $error("%s", msg);
        endfunction

        function void check_result(rsp_item_t got);
            rsp_item_t want;
            if (owed_results.size() == 0)
            begin
                report($sformatf("result with no item pending: index %0d status %0d",
                                 got.result_index, got.status));
                return;
            end
            want = owed_results.pop_front();
            checked++;
            if (got.result_index !== want.result_index)
                report($sformatf("result_index: expected %0d, actual %0d",
                                 want.result_index, got.result_index));
            if (got.status !== want.status)
                report($sformatf("status: expected %0d, actual %0d",
                                 want.status, got.status));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_item_t req_item = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_item_t rsp_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;

    free_map_checker sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;

    hierarchical_bitmap_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results owed.",
                     cycle_count, sb.owed_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: check accepted items, then choose the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp_item);
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_request(req_item_t it);
        req_valid <= 1'b1;
        req_item <= it;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_op(logic [OP_W-1:0] op, int unsigned pos, bit fill);
        req_item_t it;
        it.opcode = op;
        it.position = POS_W'(pos);
        it.fill_free = fill;
        send_request(it);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.object_count = value;
    endtask

    function automatic logic [POS_W-1:0] pick_position(int unsigned lim);
        int unsigned sel;
        sel = $urandom_range(99);
        if (lim == 0 || sel < 30)
            return POS_W'($urandom_range(OBJ_TOTAL - 1));
        if (sel < 40)
            return POS_W'((lim >= OBJ_TOTAL) ? OBJ_TOTAL - 1 : lim);
        if (sel < 50)
            return POS_W'(lim - 1);
        return POS_W'($urandom_range(lim - 1));
    endfunction

    function automatic req_item_t random_request();
        req_item_t it;
        int unsigned sel;
        sel = $urandom_range(99);
        it.position = pick_position(sb.count_limit());
        it.fill_free = 1'($urandom_range(1));
        if (sel < 3)
        begin
            it.opcode = OP_INIT;
            it.fill_free = ($urandom_range(99) < 85);
        end
        else if (sel < 35)
            it.opcode = OP_ALLOC;
        else if (sel < 60)
            it.opcode = OP_FREE;
        else if (sel < 72)
            it.opcode = OP_MARK;
        else if (sel < 96)
            it.opcode = OP_FIND;
        else
            it.opcode = OP_W'($urandom_range(5, 7));
        return it;
    endfunction

    initial
    begin
        logic [CNT_W-1:0] phase_count[PHASES];
        bit phase_init[PHASES];

        phase_count = '{11'd1024, 11'd37, 11'd1, 11'd2047, 11'd0,
                        11'd500, 11'd64, 11'd1000, 11'd1024};
        // Phases that skip the init keep the map from the previous count, so a lowered
        // count leaves free bits above it that searches must ignore.
        phase_init = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed item sequence on the reset map: everything busy, full count.
        send_op(OP_FIND, 0, 1'b0);
        send_op(OP_ALLOC, 17, 1'b0);
        send_op(3'd5, 1023, 1'b1);
        send_op(3'd6, 0, 1'b0);
        send_op(3'd7, 512, 1'b1);
        send_op(OP_FREE, 5, 1'b0);
        send_op(OP_FIND, 0, 1'b0);
        send_op(OP_FIND, 6, 1'b0);
        send_op(OP_FREE, 1023, 1'b1);
        send_op(OP_FIND, 6, 1'b0);
        send_op(OP_ALLOC, 0, 1'b0);
        send_op(OP_MARK, 1023, 1'b0);
        send_op(OP_MARK, 1023, 1'b0);
        send_op(OP_FREE, 0, 1'b0);
        send_op(OP_FREE, 0, 1'b0);
        send_op(OP_INIT, 1023, 1'b1);
        send_op(OP_ALLOC, 0, 1'b0);
        send_op(OP_ALLOC, 0, 1'b0);
        send_op(OP_FIND, 1023, 1'b0);
        send_op(OP_MARK, 31, 1'b0);
        send_op(OP_FIND, 31, 1'b0);
        send_op(OP_INIT, 0, 1'b0);
        send_op(OP_FIND, 0, 1'b1);
        send_op(OP_ALLOC, 1023, 1'b1);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 3)
            begin
                send_idle_pct = 24;
                recv_stall_pct = 58;
            end
            else if (p < 6)
            begin
                send_idle_pct = 58;
                recv_stall_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            write_count(phase_count[p]);
            @(posedge clk);
            if (phase_init[p])
                send_op(OP_INIT, $urandom_range(OBJ_TOTAL - 1), 1'b1);
            // With no idling on either side, a long hold on results backs the block up.
            if (p == 7)
                hold_left = HOLD_CYCLES;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_request(random_request());
            drain();
        end

        repeat (200) @(posedge clk);
        if (sb.owed_results.size() != 0)
        begin
            sb.errors++;
            $error("%0d expected results never arrived", sb.owed_results.size());
        end
        $display("Checked %0d results over %0d count settings: %0d init, %0d alloc (%0d granted),",
                 sb.checked, PHASES, sb.op_seen[OP_INIT], sb.op_seen[OP_ALLOC], sb.grants);
        $display("%0d free, %0d mark busy, %0d find, %0d undefined; %0d mismatches.",
                 sb.op_seen[OP_FREE], sb.op_seen[OP_MARK], sb.op_seen[OP_FIND],
                 sb.op_seen[5] + sb.op_seen[6] + sb.op_seen[7], sb.errors);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/hba_pkg.sv
src/hba_ctrl.sv
src/hba_datapath.sv
src/hierarchical_bitmap_allocator.sv
dv/tb_hierarchical_bitmap_allocator.sv
